### hw/rtl/tfn_pkg.sv
// Package for the triangle face normal unit.
// Holds the fixed result widths, the widths of the rounding datapath and its types.
// No dependencies.
package tfn_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int INDEX_WIDTH_DEF = 16;

    // Normal components are signed Q1.14; 1.0 is ONE_Q14.
    localparam int NRM_W      = 16;
    localparam int ONE_Q14    = 16384;
    // Each cross product magnitude is reduced to below 2^RED_W before rounding.
    localparam int RED_W      = 16;
    localparam int SQ_W       = 2 * RED_W;
    localparam int SUM_W      = SQ_W + 2;
    // Code bits of a magnitude in 0..16384.
    localparam int Q_W        = 15;
    localparam int FRAC_SHIFT = 30;
    localparam int ACC_W      = 72;

    typedef logic        [RED_W-1:0] t_red;
    typedef logic        [SQ_W-1:0]  t_sq;
    typedef logic        [SUM_W-1:0] t_sum;
    typedef logic        [Q_W-1:0]   t_code;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [NRM_W-1:0] t_nrm;

endpackage

### hw/rtl/tfn_if.sv
// Channel interfaces of the triangle face normal unit: triangle requests in, normals out.
// Depends on tfn_pkg.
interface tfn_tri_if import tfn_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic        [INDEX_WIDTH-1:0] index_a;
    logic        [INDEX_WIDTH-1:0] index_b;
    logic        [INDEX_WIDTH-1:0] index_c;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;

    modport source (output valid, index_a, index_b, index_c, ax, ay, az, bx, by, bz,
                    cx, cy, cz, input ready);
    modport sink   (input valid, index_a, index_b, index_c, ax, ay, az, bx, by, bz,
                    cx, cy, cz, output ready);
endinterface

interface tfn_nrm_if import tfn_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [INDEX_WIDTH-1:0]  out_index_a;
    logic [INDEX_WIDTH-1:0]  out_index_b;
    logic [INDEX_WIDTH-1:0]  out_index_c;
    t_nrm                    normal_x;
    t_nrm                    normal_y;
    t_nrm                    normal_z;
    logic                    degenerate;

    modport source (output valid, out_index_a, out_index_b, out_index_c, normal_x,
                    normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, out_index_a, out_index_b, out_index_c, normal_x,
                    normal_y, normal_z, degenerate, output ready);
endinterface

### hw/rtl/triangle_face_normal_unit.sv
// Triangle face normal unit: edges, cross product, block reduction and unit rounding.
// Depends on tfn_pkg, tfn_tri_if, tfn_nrm_if and tfn_round_pipe.
//
//   Channel  Direction  Moves                                   Handshake
//   i_tri    in         three indices and three corners A, B, C  valid/ready
//   o_nrm    out        indices, Q1.14 normal, degenerate flag   valid/ready
//
// One triangle is accepted every cycle while the output is not stalled.
// The depth is set by the rounding, which settles one code bit per stage.
// Reset empties every stage; payload registers are not reset.
// A stall on the output holds the whole pipeline, so nothing is lost or repeated.
module triangle_face_normal_unit import tfn_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfn_tri_if.sink   i_tri,
    tfn_nrm_if.source o_nrm
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int CUT = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
    localparam int EW  = DW - CUT;
    localparam int PW  = 2 * EW;
    localparam int XW  = 2 * EW + 1;
    localparam int MW  = 2 * EW;
    localparam int NG  = (MW + 7) / 8;
    localparam int OW  = NG * 8;
    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int LW  = $clog2(OW + 1);
    localparam int SHW = $clog2(MW + 1);
    localparam int PRE = 8;
    localparam int IDX_DEPTH = PRE + Q_W;
    localparam int FLG_DEPTH = PRE - 3 + Q_W;

    typedef logic signed [EW-1:0] t_edge;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic        [MW-1:0] t_mag;
    typedef struct packed {
        logic [INDEX_WIDTH-1:0] a;
        logic [INDEX_WIDTH-1:0] b;
        logic [INDEX_WIDTH-1:0] c;
    } t_idx;
    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } t_flg;

    // Edge component q - p, its magnitude cut to EW-1 bits for wide coordinates.
    function automatic t_edge f_edge(input logic signed [COORD_WIDTH-1:0] p,
                                     input logic signed [COORD_WIDTH-1:0] q);
        logic signed [DW-1:0] d;
        logic        [DW-1:0] m;
        logic        [EW-2:0] c;
        d = DW'(q) - DW'(p);
        m = d[DW-1] ? DW'(-d) : DW'(d);
        c = (EW-1)'(m >> CUT);
        return d[DW-1] ? -$signed({1'b0, c}) : $signed({1'b0, c});
    endfunction

    logic en;
    logic r_v [PRE];
    logic r_o_valid;

    t_idx r_idx [IDX_DEPTH];
    t_flg r_flg [FLG_DEPTH];

    t_edge r1_e1 [3];
    t_edge r1_e2 [3];
    t_prod r2_p  [6];
    t_mag  r3_m  [3];
    t_flg  r3_f;
    logic  [OW-1:0] n4_or;
    logic  [OW-1:0] r4_or;
    logic  [NG-1:0] r4_grp;
    t_mag  r4_m  [3];
    logic  [SHW-1:0] r5_sh;
    t_mag  r5_m  [3];
    t_red  r6_r  [3];
    t_sq   r7_sq [3];
    t_sum  r8_sum;
    t_sq   r8_sq [3];

    logic  [XW-1:0] n3_c [3];
    logic  [SHW-1:0] n5_sh;
    logic  rp_valid;
    t_code rp_code [3];
    t_nrm  n_nrm [3];
    t_nrm  r_nrm [3];
    t_flg  fo;

    assign en          = !r_o_valid || o_nrm.ready;
    assign i_tri.ready = en;

    // Valid bits of the stages ahead of the rounding pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PRE; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_tri.valid;
            for (int s = 1; s < PRE; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx[0] <= '{a: i_tri.index_a, b: i_tri.index_b, c: i_tri.index_c};
            for (int s = 1; s < IDX_DEPTH; s++) begin
                r_idx[s] <= r_idx[s-1];
            end
            r_flg[0] <= r3_f;
            for (int s = 1; s < FLG_DEPTH; s++) begin
                r_flg[s] <= r_flg[s-1];
            end
        end
    end

    // Stage 1: edge vectors from the first corner.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_e1[0] <= f_edge(i_tri.ax, i_tri.bx);
            r1_e1[1] <= f_edge(i_tri.ay, i_tri.by);
            r1_e1[2] <= f_edge(i_tri.az, i_tri.bz);
            r1_e2[0] <= f_edge(i_tri.ax, i_tri.cx);
            r1_e2[1] <= f_edge(i_tri.ay, i_tri.cy);
            r1_e2[2] <= f_edge(i_tri.az, i_tri.cz);
        end
    end

    // Stage 2: the six partial products of the cross product.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p[0] <= PW'(r1_e1[1]) * PW'(r1_e2[2]);
            r2_p[1] <= PW'(r1_e1[2]) * PW'(r1_e2[1]);
            r2_p[2] <= PW'(r1_e1[2]) * PW'(r1_e2[0]);
            r2_p[3] <= PW'(r1_e1[0]) * PW'(r1_e2[2]);
            r2_p[4] <= PW'(r1_e1[0]) * PW'(r1_e2[1]);
            r2_p[5] <= PW'(r1_e1[1]) * PW'(r1_e2[0]);
        end
    end

    // Stage 3: cross product, split into magnitude and sign.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_c[i] = XW'($signed(r2_p[2*i])) - XW'($signed(r2_p[2*i+1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_m[i]     <= n3_c[i][XW-1] ? MW'(-n3_c[i]) : MW'(n3_c[i]);
                r3_f.neg[i] <= n3_c[i][XW-1];
            end
            r3_f.deg <= (n3_c[0] == '0) && (n3_c[1] == '0) && (n3_c[2] == '0);
        end
    end

    // Stage 4: the largest magnitude has the same length as the OR of all three.
    assign n4_or = OW'(r3_m[0] | r3_m[1] | r3_m[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_or <= n4_or;
            for (int g = 0; g < NG; g++) begin
                r4_grp[g] <= |n4_or[8*g +: 8];
            end
            for (int i = 0; i < 3; i++) begin
                r4_m[i] <= r3_m[i];
            end
        end
    end

    // Stage 5: find the top byte, then the top bit inside it, and the reduction shift.
    always_comb begin
        logic [GW-1:0] top;
        logic [7:0]    byte_v;
        logic [2:0]    bpos;
        logic [LW-1:0] len;
        top    = '0;
        byte_v = '0;
        bpos   = '0;
        for (int g = 0; g < NG; g++) begin
            if (r4_grp[g]) begin
                top    = GW'(g);
                byte_v = r4_or[8*g +: 8];
            end
        end
        for (int b = 0; b < 8; b++) begin
            if (byte_v[b]) begin
                bpos = 3'(b);
            end
        end
        len = LW'(top) * LW'(8) + LW'(bpos) + LW'(1);
        n5_sh = (len > LW'(RED_W)) ? SHW'(len - LW'(RED_W)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sh <= n5_sh;
            for (int i = 0; i < 3; i++) begin
                r5_m[i] <= r4_m[i];
            end
        end
    end

    // Stages 6 to 8: reduced components, their squares and the sum of squares.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_r[i]  <= RED_W'(r5_m[i] >> r5_sh);
                r7_sq[i] <= SQ_W'(r6_r[i]) * SQ_W'(r6_r[i]);
                r8_sq[i] <= r7_sq[i];
            end
            r8_sum <= SUM_W'(r7_sq[0]) + SUM_W'(r7_sq[1]) + SUM_W'(r7_sq[2]);
        end
    end

    tfn_round_pipe u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[PRE-1]),
        .i_sum   (r8_sum),
        .i_sq    (r8_sq),
        .o_valid (rp_valid),
        .o_code  (rp_code)
    );

    // Output register: sign back on, zero normal for a degenerate triangle.
    assign fo = r_flg[FLG_DEPTH-1];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (fo.deg) begin
                n_nrm[i] = '0;
            end else if (fo.neg[i]) begin
                n_nrm[i] = -t_nrm'({1'b0, rp_code[i]});
            end else begin
                n_nrm[i] = t_nrm'({1'b0, rp_code[i]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= rp_valid;
        end
    end

    t_idx r_o_idx;
    logic r_o_deg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_idx <= r_idx[IDX_DEPTH-1];
            r_o_deg <= fo.deg;
            for (int i = 0; i < 3; i++) begin
                r_nrm[i] <= n_nrm[i];
            end
        end
    end

    assign o_nrm.valid       = r_o_valid;
    assign o_nrm.out_index_a = r_o_idx.a;
    assign o_nrm.out_index_b = r_o_idx.b;
    assign o_nrm.out_index_c = r_o_idx.c;
    assign o_nrm.normal_x    = r_nrm[0];
    assign o_nrm.normal_y    = r_nrm[1];
    assign o_nrm.normal_z    = r_nrm[2];
    assign o_nrm.degenerate  = r_o_deg;

endmodule

### hw/rtl/tfn_round_pipe.sv
// Pipelined rounding of the three reduced components to unit codes, one code bit a stage.
// Depends on tfn_pkg.
module tfn_round_pipe import tfn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_sum  i_sum,
    input  t_sq   i_sq [3],
    output logic  o_valid,
    output t_code o_code [3]
);

    localparam int STEPS = Q_W;

    // Per stage and component: P = (2q-1)^2 * S and U = (2q-1) * S for the code q so far.
    logic  r_vld [STEPS];
    t_acc  r_p   [STEPS][3];
    t_acc  r_u   [STEPS][3];
    t_code r_q   [STEPS][3];
    t_sum  r_s   [STEPS];
    t_sq   r_sq  [STEPS][3];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int J = STEPS - 1 - k;

        logic  a_v;
        t_sum  a_s;
        t_sq   a_sq [3];
        t_acc  a_p  [3];
        t_acc  a_u  [3];
        t_code a_q  [3];
        t_acc  cand [3];
        t_acc  rhs  [3];
        t_acc  n_p  [3];
        t_acc  n_u  [3];
        t_code n_q  [3];

        if (k == 0) begin : g_first
            always_comb begin
                a_v = i_valid;
                a_s = i_sum;
                for (int i = 0; i < 3; i++) begin
                    a_sq[i] = i_sq[i];
                    a_p[i]  = t_acc'(i_sum);
                    a_u[i]  = -t_acc'(i_sum);
                    a_q[i]  = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                a_v = r_vld[k-1];
                a_s = r_s[k-1];
                for (int i = 0; i < 3; i++) begin
                    a_sq[i] = r_sq[k-1][i];
                    a_p[i]  = r_p[k-1][i];
                    a_u[i]  = r_u[k-1][i];
                    a_q[i]  = r_q[k-1][i];
                end
            end
        end

        // Trying q + 2^J adds 2^(J+2)*U + 2^(2J+2)*S to P; the bit stays when P fits.
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cand[i] = a_p[i] + (a_u[i] <<< (J + 2)) + (t_acc'(a_s) << (2 * J + 2));
                rhs[i]  = t_acc'(a_sq[i]) << FRAC_SHIFT;
                if (cand[i] <= rhs[i]) begin
                    n_p[i] = cand[i];
                    n_u[i] = a_u[i] + (t_acc'(a_s) << (J + 1));
                    n_q[i] = a_q[i] | (t_code'(1) << J);
                end else begin
                    n_p[i] = a_p[i];
                    n_u[i] = a_u[i];
                    n_q[i] = a_q[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k] <= a_s;
                for (int i = 0; i < 3; i++) begin
                    r_sq[k][i] <= a_sq[i];
                    r_p[k][i]  <= n_p[i];
                    r_u[k][i]  <= n_u[i];
                    r_q[k][i]  <= n_q[i];
                end
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_code[i] = r_q[STEPS-1][i];
        end
    end

endmodule

### hw/rtl/tfn_checker.sv
// Port checker for the triangle face normal unit, bound to the top level.
// Depends on tfn_pkg and triangle_face_normal_unit.
module tfn_checker import tfn_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_deg,
    input t_nrm i_nx,
    input t_nrm i_ny,
    input t_nrm i_nz
);

    localparam t_nrm POS_ONE = t_nrm'(ONE_Q14);
    localparam t_nrm NEG_ONE = -t_nrm'(ONE_Q14);

    // A request is taken whenever the output register is free or being emptied.
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow the output register");

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_nx) && $stable(i_ny)
        && $stable(i_nz) && $stable(i_deg))
        else $error("stalled result changed");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_deg |-> i_nx == '0 && i_ny == '0 && i_nz == '0)
        else $error("degenerate result with nonzero normal");

    // A real normal has at least one nonzero component and stays in range.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_deg |-> (i_nx != '0 || i_ny != '0 || i_nz != '0)
        && i_nx <= POS_ONE && i_nx >= NEG_ONE && i_ny <= POS_ONE && i_ny >= NEG_ONE
        && i_nz <= POS_ONE && i_nz >= NEG_ONE)
        else $error("normal out of range");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_tri.ready),
    .i_out_valid (o_nrm.valid),
    .i_out_ready (o_nrm.ready),
    .i_deg       (o_nrm.degenerate),
    .i_nx        (o_nrm.normal_x),
    .i_ny        (o_nrm.normal_y),
    .i_nz        (o_nrm.normal_z)
);
